// ===== hdl/bcdl_pkg.sv =====
// Shared constants for the button click / double-click / long-press detector.
package bcdl_pkg;

  localparam int unsigned TIME_W  = 32;
  localparam int unsigned CFG_W   = 16;
  localparam int unsigned PHASE_W = 3;
  localparam int unsigned EVENT_W = 2;
  localparam int unsigned CIDX_W  = 2;

  typedef logic [PHASE_W-1:0] phase_t;
  typedef logic [EVENT_W-1:0] event_t;
  typedef logic [CIDX_W-1:0]  cidx_t;

  localparam phase_t PH_IDLE   = 3'd0;
  localparam phase_t PH_DEB1   = 3'd1;
  localparam phase_t PH_HELD1  = 3'd2;
  localparam phase_t PH_LONG   = 3'd3;
  localparam phase_t PH_WINDOW = 3'd4;
  localparam phase_t PH_DEB2   = 3'd5;
  localparam phase_t PH_HELD2  = 3'd6;

  localparam event_t EV_NONE   = 2'd0;
  localparam event_t EV_SINGLE = 2'd1;
  localparam event_t EV_DOUBLE = 2'd2;
  localparam event_t EV_LONG   = 2'd3;

  localparam cidx_t REG_DEBOUNCE = 2'd0;
  localparam cidx_t REG_LONG     = 2'd1;
  localparam cidx_t REG_WINDOW   = 2'd2;

  localparam logic [CFG_W-1:0] DEBOUNCE_RST = 16'd25;
  localparam logic [CFG_W-1:0] LONG_RST     = 16'd2000;
  localparam logic [CFG_W-1:0] WINDOW_RST   = 16'd250;

endpackage

// ===== hdl/button_click_double_long_detector.sv =====
// Top level: key scan stream in, click / double-click / long-press event stream out.
//
// Each input word is one scan (key level, millisecond timestamp); each scan yields
// exactly one output word with the event code (0 none, 1 single, 2 double, 3 long).
// The block takes one scan per clock while out_tready stays high: a scan is registered,
// then the state machine step (one 32-bit wrapping subtract and a compare) runs into
// the output register. The user must write the timing registers through the cfg port
// only while idle; the block itself does not enforce this.
module button_click_double_long_detector (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // [0] key_level, [32:1] now_ms, [39:33] zero
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // [1:0] key_event, [7:2] zero
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  logic [bcdl_pkg::CFG_W-1:0]  debounce_r;
  logic [bcdl_pkg::CFG_W-1:0]  long_r;
  logic [bcdl_pkg::CFG_W-1:0]  window_r;

  logic                        in_valid_r;
  logic                        key_r;
  logic [bcdl_pkg::TIME_W-1:0] now_r;

  bcdl_pkg::phase_t            phase_r;
  bcdl_pkg::phase_t            phase_nxt;
  logic [bcdl_pkg::TIME_W-1:0] entry_r;
  logic [bcdl_pkg::TIME_W-1:0] entry_nxt;
  logic [bcdl_pkg::TIME_W-1:0] elapsed;

  logic                        out_valid_r;
  bcdl_pkg::event_t            event_r;
  bcdl_pkg::event_t            event_nxt;

  logic                        advance;
  logic                        proc;
  logic                        deb_done;
  logic                        long_done;
  logic                        win_done;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      debounce_r <= bcdl_pkg::DEBOUNCE_RST;
      long_r     <= bcdl_pkg::LONG_RST;
      window_r   <= bcdl_pkg::WINDOW_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        bcdl_pkg::REG_DEBOUNCE: debounce_r <= cfg_data;
        bcdl_pkg::REG_LONG:     long_r     <= cfg_data;
        bcdl_pkg::REG_WINDOW:   window_r   <= cfg_data;
        default: ;
      endcase
    end
  end

  assign advance   = !out_valid_r || out_tready;
  assign proc      = in_valid_r && advance;
  assign in_tready = !in_valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      key_r <= in_tdata[0];
      now_r <= in_tdata[32:1];
    end
  end

  assign elapsed   = now_r - entry_r;
  assign deb_done  = elapsed >= {16'd0, debounce_r};
  assign long_done = elapsed >= {16'd0, long_r};
  assign win_done  = elapsed >= {16'd0, window_r};

  always_comb begin
    phase_nxt = phase_r;
    entry_nxt = entry_r;
    event_nxt = bcdl_pkg::EV_NONE;
    case (phase_r)
      bcdl_pkg::PH_IDLE: begin
        if (key_r) begin
          phase_nxt = bcdl_pkg::PH_DEB1;
          entry_nxt = now_r;
        end
      end
      bcdl_pkg::PH_DEB1: begin
        if (!key_r) begin
          phase_nxt = bcdl_pkg::PH_IDLE;
        end else if (deb_done) begin
          phase_nxt = bcdl_pkg::PH_HELD1;
          entry_nxt = now_r;
        end
      end
      bcdl_pkg::PH_HELD1: begin
        if (!key_r) begin
          phase_nxt = bcdl_pkg::PH_WINDOW;
          entry_nxt = now_r;
        end else if (long_done) begin
          phase_nxt = bcdl_pkg::PH_LONG;
          event_nxt = bcdl_pkg::EV_LONG;
        end
      end
      bcdl_pkg::PH_LONG: begin
        if (!key_r) phase_nxt = bcdl_pkg::PH_IDLE;
      end
      bcdl_pkg::PH_WINDOW: begin
        if (key_r) begin
          phase_nxt = bcdl_pkg::PH_DEB2;
          entry_nxt = now_r;
        end else if (win_done) begin
          phase_nxt = bcdl_pkg::PH_IDLE;
          event_nxt = bcdl_pkg::EV_SINGLE;
        end
      end
      bcdl_pkg::PH_DEB2: begin
        // noise: back to window, timed from second debounce entry
        if (!key_r) begin
          phase_nxt = bcdl_pkg::PH_WINDOW;
        end else if (deb_done) begin
          phase_nxt = bcdl_pkg::PH_HELD2;
          entry_nxt = now_r;
        end
      end
      bcdl_pkg::PH_HELD2: begin
        if (!key_r) begin
          phase_nxt = bcdl_pkg::PH_IDLE;
          event_nxt = bcdl_pkg::EV_DOUBLE;
        end
      end
      default: phase_nxt = bcdl_pkg::PH_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= bcdl_pkg::PH_IDLE;
      entry_r <= '0;
    end else if (proc) begin
      phase_r <= phase_nxt;
      entry_r <= entry_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= in_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (proc) event_r <= event_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {6'd0, event_r};

`ifndef SYNTHESIS
  a_long_enters_wait: assert property (@(posedge clk) disable iff (!rst_n)
    proc && event_nxt == bcdl_pkg::EV_LONG |=> phase_r == bcdl_pkg::PH_LONG)
    else $error("long press event without long-press phase");

  a_double_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
    proc && event_nxt == bcdl_pkg::EV_DOUBLE |=> phase_r == bcdl_pkg::PH_IDLE)
    else $error("double click event did not return to idle");

  a_press_stamps_entry: assert property (@(posedge clk) disable iff (!rst_n)
    proc && phase_r == bcdl_pkg::PH_IDLE && key_r |=> entry_r == $past(now_r))
    else $error("debounce entry time not captured");

  a_stall_only_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> in_valid_r && out_valid_r && !out_tready)
    else $error("input stalled while pipeline can move");
`endif

endmodule

// ===== test/tb_top.sv =====
// Self-checking testbench for the key click / double-click / long-press detector.
`timescale 1ns / 100ps

module tb_top;

  localparam bcdl_pkg::cidx_t REG_UNUSED  = 2'd3;
  localparam int              STALL_LIMIT = 2000;
  localparam int              PHASE_SCANS = 90;

  class key_event_tracker;
    logic [bcdl_pkg::CFG_W-1:0]  debounce_ms;
    logic [bcdl_pkg::CFG_W-1:0]  long_ms;
    logic [bcdl_pkg::CFG_W-1:0]  window_ms;
    bcdl_pkg::phase_t            phase;
    logic [bcdl_pkg::TIME_W-1:0] entry_ms;
    bcdl_pkg::event_t            pending_events[$];
    int                          words_seen;
    int                          errors;

    function new();
      debounce_ms = bcdl_pkg::DEBOUNCE_RST;
      long_ms     = bcdl_pkg::LONG_RST;
      window_ms   = bcdl_pkg::WINDOW_RST;
      phase       = bcdl_pkg::PH_IDLE;
      entry_ms    = '0;
      words_seen  = 0;
      errors      = 0;
    endfunction

    function void set_reg(bcdl_pkg::cidx_t idx, logic [bcdl_pkg::CFG_W-1:0] val);
      case (idx)
        bcdl_pkg::REG_DEBOUNCE: debounce_ms = val;
        bcdl_pkg::REG_LONG:     long_ms = val;
        bcdl_pkg::REG_WINDOW:   window_ms = val;
        default: ;
      endcase
    endfunction

    function void note_scan(logic down, logic [bcdl_pkg::TIME_W-1:0] now);
      logic [bcdl_pkg::TIME_W-1:0] elapsed;
      bcdl_pkg::event_t            ev;
      elapsed = now - entry_ms;
      ev = bcdl_pkg::EV_NONE;
      case (phase)
        bcdl_pkg::PH_IDLE: begin
          if (down) begin
            phase = bcdl_pkg::PH_DEB1;
            entry_ms = now;
          end
        end
        bcdl_pkg::PH_DEB1: begin
          if (!down) begin
            phase = bcdl_pkg::PH_IDLE;
          end else if (elapsed >= {16'd0, debounce_ms}) begin
            phase = bcdl_pkg::PH_HELD1;
            entry_ms = now;
          end
        end
        bcdl_pkg::PH_HELD1: begin
          if (!down) begin
            phase = bcdl_pkg::PH_WINDOW;
            entry_ms = now;
          end else if (elapsed >= {16'd0, long_ms}) begin
            phase = bcdl_pkg::PH_LONG;
            ev = bcdl_pkg::EV_LONG;
          end
        end
        bcdl_pkg::PH_LONG: begin
          if (!down) phase = bcdl_pkg::PH_IDLE;
        end
        bcdl_pkg::PH_WINDOW: begin
          if (down) begin
            phase = bcdl_pkg::PH_DEB2;
            entry_ms = now;
          end else if (elapsed >= {16'd0, window_ms}) begin
            phase = bcdl_pkg::PH_IDLE;
            ev = bcdl_pkg::EV_SINGLE;
          end
        end
        // noise falls back to the window without restoring its start time
        bcdl_pkg::PH_DEB2: begin
          if (!down) begin
            phase = bcdl_pkg::PH_WINDOW;
          end else if (elapsed >= {16'd0, debounce_ms}) begin
            phase = bcdl_pkg::PH_HELD2;
            entry_ms = now;
          end
        end
        bcdl_pkg::PH_HELD2: begin
          if (!down) begin
            phase = bcdl_pkg::PH_IDLE;
            ev = bcdl_pkg::EV_DOUBLE;
          end
        end
        default: phase = bcdl_pkg::PH_IDLE;
      endcase
      pending_events.push_back(ev);
    endfunction

    function int pending();
      return pending_events.size();
    endfunction

    task report(string msg);
      $display("mismatch: %s", msg);
      errors++;
    endtask

    task check_word(logic [7:0] word);
      bcdl_pkg::event_t ev;
      if (pending_events.size() == 0) begin
        report($sformatf("output word %0d (0x%02h) with no scan pending", words_seen, word));
      end else begin
        ev = pending_events.pop_front();
        if (word !== {6'd0, ev})
          report($sformatf("word %0d: expected event %0d, got 0x%02h", words_seen, ev, word));
      end
      words_seen++;
    endtask
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [39:0] in_tdata = '0;   // [0] key_level, [32:1] now_ms, [39:33] zero
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [7:0]  out_tdata;       // [1:0] key_event, [7:2] zero
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = '0;
  logic [15:0] cfg_data = '0;

  key_event_tracker            tracker = new();
  logic [bcdl_pkg::TIME_W-1:0] clock_ms;
  int                          n_scans;
  int                          src_idle_pct;
  int                          sink_stall_pct;
  int                          stall_cycles;

  button_click_double_long_detector dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) tracker.check_word(out_tdata);
      out_tready <= ($urandom_range(99) >= sink_stall_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) ||
        (cfg_valid && cfg_ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("status: fail");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  function automatic logic [bcdl_pkg::TIME_W-1:0] near(logic [bcdl_pkg::CFG_W-1:0] thr);
    logic [bcdl_pkg::TIME_W-1:0] t;
    t = {16'd0, thr};
    if (thr == '0) return $urandom_range(1);
    return t - 1 + $urandom_range(2);
  endfunction

  function automatic logic [bcdl_pkg::TIME_W-1:0] short_of(logic [bcdl_pkg::CFG_W-1:0] thr);
    logic [bcdl_pkg::TIME_W-1:0] t;
    t = {16'd0, thr};
    if (thr == '0) return '0;
    return $urandom_range(t - 1);
  endfunction

  task send_scan(logic down, logic [bcdl_pkg::TIME_W-1:0] now);
    in_tvalid <= 1'b1;
    in_tdata  <= {7'd0, now, down};
    do @(posedge clk); while (!in_tready);
    tracker.note_scan(down, now);
    n_scans++;
    if ($urandom_range(99) < src_idle_pct) begin
      in_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < src_idle_pct);
    end
  endtask

  task scan(logic down, logic [bcdl_pkg::TIME_W-1:0] dt);
    clock_ms = clock_ms + dt;
    send_scan(down, clock_ms);
  endtask

  task write_reg(bcdl_pkg::cidx_t idx, logic [bcdl_pkg::CFG_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    tracker.set_reg(idx, val);
  endtask

  task set_timing(logic [bcdl_pkg::CFG_W-1:0] deb, logic [bcdl_pkg::CFG_W-1:0] lng,
                  logic [bcdl_pkg::CFG_W-1:0] win);
    write_reg(bcdl_pkg::REG_DEBOUNCE, deb);
    write_reg(bcdl_pkg::REG_LONG, lng);
    write_reg(bcdl_pkg::REG_WINDOW, win);
    if ($urandom_range(1)) write_reg(REG_UNUSED, 16'($urandom));
    cfg_valid <= 1'b0;
  endtask

  task wait_results();
    in_tvalid <= 1'b0;
    while (tracker.pending() != 0) @(posedge clk);
  endtask

  task drain();
    wait_results();
    repeat (4) @(posedge clk);
  endtask

  task press_confirm();
    scan(1'b1, $urandom_range(1, 40));
    scan(1'b1, near(tracker.debounce_ms));
    scan(1'b1, $urandom_range(0, 20));
  endtask

  task gesture_click();
    press_confirm();
    scan(1'b0, $urandom_range(0, 20));
    scan(1'b0, near(tracker.window_ms));
    scan(1'b0, near(tracker.window_ms));
  endtask

  task gesture_double();
    press_confirm();
    scan(1'b0, $urandom_range(0, 20));
    scan(1'b1, $urandom_range(0, tracker.window_ms));
    scan(1'b1, near(tracker.debounce_ms));
    scan(1'b1, $urandom_range(0, 20));
    scan(1'b0, $urandom_range(0, 20));
    scan(1'b0, near(tracker.window_ms));
  endtask

  task gesture_long();
    scan(1'b1, $urandom_range(1, 40));
    scan(1'b1, near(tracker.debounce_ms));
    scan(1'b1, near(tracker.long_ms));
    scan(1'b1, near(tracker.long_ms));
    scan(1'b1, $urandom_range(0, 100));
    scan(1'b0, $urandom_range(1, 20));
    scan(1'b0, $urandom_range(0, 20));
  endtask

  task gesture_bounce();
    scan(1'b1, $urandom_range(1, 40));
    if ($urandom_range(1)) scan(1'b1, short_of(tracker.debounce_ms));
    scan(1'b0, $urandom_range(0, 10));
  endtask

  task gesture_second_bounce();
    press_confirm();
    scan(1'b0, $urandom_range(0, 20));
    scan(1'b1, short_of(tracker.window_ms));
    scan(1'b0, short_of(tracker.debounce_ms));
    scan(1'b0, near(tracker.window_ms));
    scan(1'b0, near(tracker.window_ms));
  endtask

  task gesture_noise();
    clock_ms = $urandom_range(1) ? $urandom : 32'hFFFF_FFFF - $urandom_range(200);
    repeat ($urandom_range(1, 3)) scan($urandom_range(1) != 0, $urandom);
  endtask

  task random_gesture();
    int pick;
    pick = $urandom_range(99);
    if (pick < 25)      gesture_click();
    else if (pick < 50) gesture_double();
    else if (pick < 68) gesture_long();
    else if (pick < 78) gesture_bounce();
    else if (pick < 88) gesture_second_bounce();
    else                gesture_noise();
    if ($urandom_range(3) == 0) scan(1'b0, $urandom_range(0, 3 * tracker.window_ms + 10));
  endtask

  initial begin
    int target;
    n_scans = 0;
    src_idle_pct = 0;
    sink_stall_pct = 0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // timestamp extremes, then click, double, long and bounce gestures across the 32-bit wrap
    send_scan(1'b0, 32'h0000_0000);
    send_scan(1'b0, 32'hFFFF_FFFF);
    clock_ms = 32'hFFFF_FFE0;
    gesture_click();
    gesture_double();
    gesture_long();
    gesture_bounce();

    for (int p = 0; p < 5; p++) begin
      case (p)
        1: set_timing('0, '0, '0);
        2: set_timing('1, '1, '1);
        3: set_timing($urandom_range(0, 40), $urandom_range(0, 300), $urandom_range(0, 120));
        4: set_timing(bcdl_pkg::DEBOUNCE_RST, bcdl_pkg::LONG_RST, bcdl_pkg::WINDOW_RST);
        default: ;
      endcase
      case (p % 4)
        0: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
        1: begin src_idle_pct = 58; sink_stall_pct = 0;  end
        2: begin src_idle_pct = 0;  sink_stall_pct = 58; end
        default: begin src_idle_pct = 20; sink_stall_pct = 20; end
      endcase
      target = n_scans + PHASE_SCANS;
      while (n_scans < target) begin
        random_gesture();
        if ($urandom_range(99) < 4) wait_results();
      end
      drain();
    end

    if (tracker.errors == 0 && tracker.pending() == 0) begin
      $display("status: pass");
    end else begin
      if (tracker.pending() != 0)
        tracker.report($sformatf("%0d expected words never arrived", tracker.pending()));
      $display("status: fail");
    end
    $finish;
  end

endmodule
